[rtl/core/bb_pkg.sv]
// ----------------------------------------------------------------------------
// bb_pkg
// Shared types, constants and helpers of the 3x3 box blur.
// ----------------------------------------------------------------------------
package bb_pkg;

  // field and register widths
  localparam int CH_W         = 8;
  localparam int PIX_W        = 3 * CH_W;
  localparam int COL_MAX_W    = 12;   // widest column index the line buffers allow
  localparam int ROW_W        = 13;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int SIZE_W       = 13;   // effective frame sizes
  localparam int OUT_COL_W    = 10;
  localparam int OUT_ROW_W    = 12;
  localparam int SUM_W        = 12;   // nine bytes at most
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 3;

  // tallest frame, tied to the row counter and size widths
  localparam int MAX_HEIGHT   = 4096;

  // register reset values
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(800);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(600);
  localparam int                      MIN_SIZE     = 3;

  // register index, taken from address bit 2
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // divide by nine: x * 3641 >> 15 is exact for x below 32768
  localparam int RECIP       = 3641;
  localparam int RECIP_SHIFT = 15;

  localparam logic [CH_W-1:0] ALPHA_FULL = 8'hFF;

  // effective frame size and restart request from the register block
  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic              restart;
  } size_cfg_t;

  // classification of one pixel: what its result looks like
  typedef struct packed {
    logic                 produce;
    logic                 m_left;
    logic                 m_right;
    logic                 m_top;
    logic                 m_bot;
    logic                 last;
    logic [COL_MAX_W-1:0] ocol;
    logic [OUT_ROW_W-1:0] orow;
  } ctl_t;

  // one queued pixel
  typedef struct packed {
    logic [PIX_W-1:0]     px;
    logic [COL_MAX_W-1:0] col;
    ctl_t                 ctl;
  } item_t;

  function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] x);
    logic [2*SUM_W-1:0] p;
    p = (2*SUM_W)'(x) * (2*SUM_W)'(RECIP);
    return p[RECIP_SHIFT +: CH_W];
  endfunction

endpackage

[rtl/core/bb_ram.sv]
// ----------------------------------------------------------------------------
// bb_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/bb_front.sv]
// ----------------------------------------------------------------------------
// bb_front
// Takes pixels, tracks the raster position and classifies each pixel.
// ----------------------------------------------------------------------------
module bb_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bb_pkg::size_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_operation,
  input  logic [7:0]        in_red,
  input  logic [7:0]        in_green,
  input  logic [7:0]        in_blue,
  input  logic              q_full,
  output logic              push,
  output bb_pkg::item_t     push_item
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic [COL_W-1:0]        col_r, col_nxt;
  logic [bb_pkg::ROW_W-1:0] row_r, row_nxt;

  logic [COL_W:0]           wm1;
  logic [COL_W-1:0]         wm1_c;
  logic [bb_pkg::ROW_W-1:0] hm1;
  logic [COL_W-1:0]         ocol;
  logic [bb_pkg::ROW_W-1:0] orow;
  logic                     produce;
  logic                     last;
  logic [COL_W:0]           col_inc;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // last column and row of the frame
  assign wm1   = cfg.width[COL_W:0] - (COL_W+1)'(1);
  assign wm1_c = wm1[COL_W-1:0];
  assign hm1   = cfg.height - bb_pkg::ROW_W'(1);

  // position of the pixel whose window this request completes
  always_comb begin
    if (col_r != '0) begin
      ocol = col_r - COL_W'(1);
      orow = row_r - bb_pkg::ROW_W'(1);
    end else begin
      ocol = wm1_c;
      orow = row_r - bb_pkg::ROW_W'(2);
    end
  end

  // the first row and one column give no result
  assign produce = (row_r != '0) && !((row_r == bb_pkg::ROW_W'(1)) && (col_r == '0));
  assign last    = produce && (orow == hm1) && (ocol == wm1_c);

  // queued request
  always_comb begin
    push_item.px          = in_operation ? '0 : {in_red, in_green, in_blue};
    push_item.col         = bb_pkg::COL_MAX_W'(col_r);
    push_item.ctl.produce = produce;
    push_item.ctl.m_left  = (ocol != '0);
    push_item.ctl.m_right = (ocol != wm1_c);
    push_item.ctl.m_top   = (orow != '0);
    push_item.ctl.m_bot   = (orow < hm1);
    push_item.ctl.last    = last;
    push_item.ctl.ocol    = bb_pkg::COL_MAX_W'(ocol);
    push_item.ctl.orow    = orow[bb_pkg::OUT_ROW_W-1:0];
  end

  // raster position of the next request
  assign col_inc = {1'b0, col_r} + (COL_W+1)'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg.restart || (push && last)) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (push) begin
      if (col_inc >= cfg.width[COL_W:0]) begin
        col_nxt = '0;
        row_nxt = row_r + bb_pkg::ROW_W'(1);
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

[rtl/core/bb_queue.sv]
// ----------------------------------------------------------------------------
// bb_queue
// Short register queue between the classifier and the filter pipeline.
// ----------------------------------------------------------------------------
module bb_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bb_pkg::item_t push_item,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output bb_pkg::item_t pop_item
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  bb_pkg::item_t entries_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_item  = entries_r[rptr_r];

  // pointer and fill count
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wptr_r] <= push_item;
    end
  end

endmodule

[rtl/core/bb_back.sv]
// ----------------------------------------------------------------------------
// bb_back
// Line buffers, 3x3 window, masked sums and divide by nine.
// ----------------------------------------------------------------------------
module bb_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  bb_pkg::item_t q_item,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_red,
  output logic [7:0]    out_green,
  output logic [7:0]    out_blue,
  output logic [7:0]    out_alpha,
  output logic [9:0]    out_column,
  output logic [11:0]   out_row,
  output logic          out_frame_last
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CH_W  = bb_pkg::CH_W;
  localparam int SUM_W = bb_pkg::SUM_W;

  logic adv;

  // line buffer read stage
  logic          s1_valid_r;
  bb_pkg::item_t s1_r;
  logic [bb_pkg::PIX_W-1:0] up_data, mid_data;

  // window stage
  logic [bb_pkg::PIX_W-1:0] win_r [9];
  logic                     s2_valid_r;
  bb_pkg::ctl_t             s2_r;

  // sum stage
  logic                        s3_valid_r;
  logic [SUM_W-1:0]            s3_sum_r [3];
  logic [bb_pkg::COL_MAX_W-1:0] s3_ocol_r;
  logic [bb_pkg::OUT_ROW_W-1:0] s3_orow_r;
  logic                        s3_last_r;
  logic [SUM_W-1:0]            col_sum [3][3];
  logic [SUM_W-1:0]            sum_nxt [3];

  // output register
  logic                         out_valid_r;
  logic [CH_W-1:0]              out_red_r, out_green_r, out_blue_r;
  logic [bb_pkg::OUT_COL_W-1:0] out_column_r;
  logic [bb_pkg::OUT_ROW_W-1:0] out_row_r;
  logic                         out_frame_last_r;

  // whole pipeline moves when the output slot is free or being taken
  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && q_valid;

  // upper line: takes the middle line's old entry
  bb_ram #(.WIDTH(bb_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk     (clk),
    .wr_en   (adv && s1_valid_r),
    .wr_addr (s1_r.col[COL_W-1:0]),
    .wr_data (mid_data),
    .rd_en   (q_pop),
    .rd_addr (q_item.col[COL_W-1:0]),
    .rd_data (up_data)
  );

  // middle line: takes the new pixel
  bb_ram #(.WIDTH(bb_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk     (clk),
    .wr_en   (adv && s1_valid_r),
    .wr_addr (s1_r.col[COL_W-1:0]),
    .wr_data (s1_r.px),
    .rd_en   (q_pop),
    .rd_addr (q_item.col[COL_W-1:0]),
    .rd_data (mid_data)
  );

  // valid bits of the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= q_valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r && s2_r.produce;
      out_valid_r <= s3_valid_r;
    end
  end

  // window shifts one column per pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (adv && s1_valid_r) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= win_r[i+3];
      end
      win_r[6] <= up_data;
      win_r[7] <= mid_data;
      win_r[8] <= s1_r.px;
    end
  end

  // column sums of in-frame neighbours, then the three columns
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int ch = 0; ch < 3; ch++) begin
        col_sum[k][ch] = '0;
        for (int j = 0; j < 3; j++) begin
          if ((k != 0 || s2_r.m_left) && (k != 2 || s2_r.m_right) &&
              (j != 0 || s2_r.m_top) && (j != 2 || s2_r.m_bot)) begin
            col_sum[k][ch] = col_sum[k][ch] +
                             SUM_W'(win_r[k*3+j][(2-ch)*CH_W +: CH_W]);
          end
        end
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      sum_nxt[ch] = col_sum[0][ch] + col_sum[1][ch] + col_sum[2][ch];
    end
  end

  // payload of the stages
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= q_item;
      s2_r <= s1_r.ctl;
      for (int ch = 0; ch < 3; ch++) begin
        s3_sum_r[ch] <= sum_nxt[ch];
      end
      s3_ocol_r        <= s2_r.ocol;
      s3_orow_r        <= s2_r.orow;
      s3_last_r        <= s2_r.last;
      out_red_r        <= bb_pkg::div9(s3_sum_r[0]);
      out_green_r      <= bb_pkg::div9(s3_sum_r[1]);
      out_blue_r       <= bb_pkg::div9(s3_sum_r[2]);
      out_column_r     <= s3_ocol_r[bb_pkg::OUT_COL_W-1:0];
      out_row_r        <= s3_orow_r;
      out_frame_last_r <= s3_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = out_red_r;
  assign out_green      = out_green_r;
  assign out_blue       = out_blue_r;
  assign out_alpha      = bb_pkg::ALPHA_FULL;
  assign out_column     = out_column_r;
  assign out_row        = out_row_r;
  assign out_frame_last = out_frame_last_r;

endmodule

[rtl/core/box_blur_3x3_rgb.sv]
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// Streaming 3x3 box blur of an RGB frame in raster order.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  in        sink       in_valid / in_stall   operation, red, green, blue
//  out       source     out_valid / out_stall red, green, blue, alpha, column,
//                                             row, frame_last
//  cfg       APB slave  psel/penable/pready   frame_width, frame_height
//
//  one pixel per cycle sustained while out_stall is low; a pixel passes the
//  queue, then the line buffer read, window, sum and divide stages
//  results lag one row and one column, so frame_width+1 flush pixels follow
//  each frame; the first frame_width+1 pixels of a frame give no result
//  reset clears position, queue, window and pipeline valids; line buffers
//  are not cleared, since stale entries never reach a sum
//  out_stall holds the whole filter pipeline; the four-entry queue keeps
//  taking pixels until it fills, then in_stall rises
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH   = 1024,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // pixel input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [9:0]  out_column,
  output logic [11:0] out_row,
  output logic        out_frame_last,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [bb_pkg::WIDTH_REG_W-1:0]  frame_width_r;
  logic [bb_pkg::HEIGHT_REG_W-1:0] frame_height_r;
  logic                            cfg_wr;
  bb_pkg::size_cfg_t               size_cfg;

  logic          q_full, q_push, q_pop, q_not_empty;
  bb_pkg::item_t q_push_item, q_pop_item;

  // register block
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= bb_pkg::WIDTH_RESET;
      frame_height_r <= bb_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        bb_pkg::REG_FRAME_WIDTH: begin
          frame_width_r <= cfg_pwdata[bb_pkg::WIDTH_REG_W-1:0];
        end
        bb_pkg::REG_FRAME_HEIGHT: begin
          frame_height_r <= cfg_pwdata[bb_pkg::HEIGHT_REG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      bb_pkg::REG_FRAME_WIDTH:  cfg_prdata = bb_pkg::CFG_DATA_W'(frame_width_r);
      bb_pkg::REG_FRAME_HEIGHT: cfg_prdata = bb_pkg::CFG_DATA_W'(frame_height_r);
      default:                  cfg_prdata = '0;
    endcase
  end

  // sizes saturated to the supported range; any register write restarts the frame
  always_comb begin
    if (frame_width_r < bb_pkg::WIDTH_REG_W'(bb_pkg::MIN_SIZE)) begin
      size_cfg.width = bb_pkg::SIZE_W'(bb_pkg::MIN_SIZE);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      size_cfg.width = bb_pkg::SIZE_W'(MAX_WIDTH);
    end else begin
      size_cfg.width = bb_pkg::SIZE_W'(frame_width_r);
    end
    if (frame_height_r < bb_pkg::HEIGHT_REG_W'(bb_pkg::MIN_SIZE)) begin
      size_cfg.height = bb_pkg::SIZE_W'(bb_pkg::MIN_SIZE);
    end else if (32'(frame_height_r) > bb_pkg::MAX_HEIGHT) begin
      size_cfg.height = bb_pkg::SIZE_W'(bb_pkg::MAX_HEIGHT);
    end else begin
      size_cfg.height = bb_pkg::SIZE_W'(frame_height_r);
    end
    size_cfg.restart = cfg_wr;
  end

  bb_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (size_cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .q_full       (q_full),
    .push         (q_push),
    .push_item    (q_push_item)
  );

  bb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (q_pop_item)
  );

  bb_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_not_empty),
    .q_item         (q_pop_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha),
    .out_column     (out_column),
    .out_row        (out_row),
    .out_frame_last (out_frame_last)
  );

endmodule

[rtl/core/bb_checker.sv]
// ----------------------------------------------------------------------------
// bb_checker
// Port-level checks on the result channel of the box blur.
// ----------------------------------------------------------------------------
module bb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue,
  input logic [7:0]  out_alpha,
  input logic [9:0]  out_column,
  input logic [11:0] out_row,
  input logic        out_frame_last
);

  // a stalled result stays and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green) &&
      $stable(out_blue) && $stable(out_column) && $stable(out_row) &&
      $stable(out_frame_last))
    else $error("stalled result changed");

  // no result straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // alpha is always opaque on a result
  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_alpha == 8'hFF)
    else $error("alpha not opaque");

  // the frame ends on its last column, which is never the first two, and never on the first row
  a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_last |-> out_column != 10'd0 && out_column != 10'd1 &&
      out_row != 12'd0)
    else $error("frame end at an impossible position");

endmodule

bind box_blur_3x3_rgb bb_checker u_bb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_red        (out_red),
  .out_green      (out_green),
  .out_blue       (out_blue),
  .out_alpha      (out_alpha),
  .out_column     (out_column),
  .out_row        (out_row),
  .out_frame_last (out_frame_last)
);

[dv/box_blur_sb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_sb_pkg
// Scoreboard for the 3x3 box blur: keeps its own line buffers, window and
// frame position, predicts the blurred pixel for every accepted request and
// checks the block's results against those predictions in order.
// ----------------------------------------------------------------------------
package box_blur_sb_pkg;

  localparam int          LINE_DEPTH   = 1024;
  localparam int          MAX_ROWS     = 4096;
  localparam int unsigned BLUR_DIVISOR = 9;
  localparam int          REPORT_LIMIT = 40;

  // operation field of a request
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [9:0]  column;
    logic [11:0] row;
    logic        last;
  } blur_result_t;

  class blur_scoreboard;
    logic [bb_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [bb_pkg::HEIGHT_REG_W-1:0] height_reg;
    logic [bb_pkg::PIX_W-1:0]        upper_line [LINE_DEPTH];
    logic [bb_pkg::PIX_W-1:0]        middle_line [LINE_DEPTH];
    logic [bb_pkg::PIX_W-1:0]        window [9];
    logic [9:0]                      next_col;
    logic [12:0]                     next_row;
    logic [22:0]                     taken;
    blur_result_t                    expected_pixels [$];
    int                              errors;

    function new();
      width_reg  = bb_pkg::WIDTH_RESET;
      height_reg = bb_pkg::HEIGHT_RESET;
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      restart();
      errors = 0;
    endfunction

    function void restart();
      next_col = '0;
      next_row = '0;
      taken    = '0;
    endfunction

    // sizes are used saturated to the supported range
    function int unsigned size_in_use(int unsigned v, int unsigned hi);
      if (v < bb_pkg::MIN_SIZE) return bb_pkg::MIN_SIZE;
      if (v > hi) return hi;
      return v;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    // any register write restarts the frame
    function void set_size(logic idx, logic [31:0] value);
      if (idx == bb_pkg::REG_FRAME_WIDTH) begin
        width_reg = value[bb_pkg::WIDTH_REG_W-1:0];
      end else begin
        height_reg = value[bb_pkg::HEIGHT_REG_W-1:0];
      end
      restart();
    endfunction

    // one accepted request: shift the neighbourhood and predict its result
    function void accept_pixel(logic op, logic [7:0] red, logic [7:0] green,
                               logic [7:0] blue);
      int unsigned              w, h, c, r, ocol, orow;
      int unsigned              sum [3];
      logic [bb_pkg::PIX_W-1:0] px, up, mid, v;
      blur_result_t             res;
      w = size_in_use(width_reg, LINE_DEPTH);
      h = size_in_use(height_reg, MAX_ROWS);
      c = next_col;
      r = next_row;
      px = (op == OP_FLUSH) ? '0 : {red, green, blue};

      // line buffers move down one row at this column
      up  = upper_line[c];
      mid = middle_line[c];
      upper_line[c]  = mid;
      middle_line[c] = px;
      for (int k = 0; k < 6; k++) window[k] = window[k+3];
      window[6] = up;
      window[7] = mid;
      window[8] = px;

      // past warm-up every request yields the pixel one row and column back
      if (taken >= w + 1) begin
        if (c >= 1) begin
          ocol = c - 1;
          orow = r - 1;
        end else begin
          ocol = w - 1;
          orow = r - 2;
        end
        sum = '{0, 0, 0};
        for (int k = 0; k < 3; k++) begin
          for (int j = 0; j < 3; j++) begin
            // neighbours outside the frame count as zero
            if (!(k == 0 && ocol == 0) && !(k == 2 && ocol >= w - 1) &&
                !(j == 0 && orow == 0) && !(j == 2 && orow >= h - 1)) begin
              v = window[k*3+j];
              sum[0] += v[23:16];
              sum[1] += v[15:8];
              sum[2] += v[7:0];
            end
          end
        end
        res.red    = 8'(sum[0] / BLUR_DIVISOR);
        res.green  = 8'(sum[1] / BLUR_DIVISOR);
        res.blue   = 8'(sum[2] / BLUR_DIVISOR);
        res.alpha  = bb_pkg::ALPHA_FULL;
        res.column = 10'(ocol);
        res.row    = 12'(orow);
        res.last   = (orow == h - 1) && (ocol == w - 1);
        expected_pixels.push_back(res);
        if (res.last) begin
          restart();
          return;
        end
      end

      taken = taken + 1'b1;
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
      next_col = 10'(c);
      next_row = 13'(r);
    endfunction

    function void compare_field(string name, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // one accepted result against the oldest prediction
    function void check_blurred(blur_result_t got);
      blur_result_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: unexpected result, expected none, actual row %0d column %0d",
                   $time, got.row, got.column);
        return;
      end
      want = expected_pixels.pop_front();
      compare_field("red", 12'(want.red), 12'(got.red));
      compare_field("green", 12'(want.green), 12'(got.green));
      compare_field("blue", 12'(want.blue), 12'(got.blue));
      compare_field("alpha", 12'(want.alpha), 12'(got.alpha));
      compare_field("column", 12'(want.column), 12'(got.column));
      compare_field("row", want.row, got.row);
      compare_field("frame_last", 12'(want.last), 12'(got.last));
    endfunction
  endclass

endpackage

[dv/box_blur_3x3_rgb_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_tb
// Streams frames of many sizes through the box blur with random gaps on the
// request side and random stalls on the result side, including long
// hold-offs that back the block up. Every result is checked against the
// scoreboard's prediction; register writes happen only while idle.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_tb;

  localparam int LIMIT_CYCLES = 600000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 820;
  localparam int MAX_WAIT     = 17;

  typedef enum {FILL_WHITE, FILL_BLACK, FILL_EXTREME, FILL_RANDOM} fill_t;
  typedef enum {FRAME_CLEAN, FRAME_NOISY, FRAME_CUT, FRAME_LONG} frame_style_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_operation = box_blur_sb_pkg::OP_PIXEL;
  logic [7:0]  in_red = '0;
  logic [7:0]  in_green = '0;
  logic [7:0]  in_blue = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic [9:0]  out_column;
  logic [11:0] out_row;
  logic        out_frame_last;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [bb_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  box_blur_sb_pkg::blur_scoreboard sb = new();

  bit          calm = 1'b1;
  int          hold_asked = 0;
  int          hold_given = 0;
  int          stall_left = 0;
  int          items_sent = 0;
  int unsigned cycle_count = 0;

  box_blur_3x3_rgb DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha),
    .out_column     (out_column),
    .out_row        (out_row),
    .out_frame_last (out_frame_last),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // both channels seen at the clock edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.accept_pixel(in_operation, in_red, in_green, in_blue);
      if (out_valid && !out_stall)
        sb.check_blurred({out_red, out_green, out_blue, out_alpha, out_column,
                          out_row, out_frame_last});
    end
  end

  // result side: random wait after each result, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_given != hold_asked) begin
      hold_given = hold_asked;
      stall_left = HOLD_CYCLES;
    end else if (out_valid && !out_stall) begin
      stall_left = calm ? 0 : $urandom_range(0, MAX_WAIT);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic write_size_reg(input logic idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_size(idx, value);
  endtask

  // one request, after a random gap unless the phase is calm
  task automatic send_item(input logic op, input logic [7:0] red,
                           input logic [7:0] green, input logic [7:0] blue);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_red       <= red;
    in_green     <= green;
    in_blue      <= blue;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // wait for every prediction to be met, then let the pipeline drain
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte(fill_t fill);
    case (fill)
      FILL_WHITE:   return 8'hFF;
      FILL_BLACK:   return 8'h00;
      FILL_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default:      return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one frame and its flush tail; tall frames are only started
  task automatic send_frame(input int w, input int h, input frame_style_t style,
                            input fill_t fill);
    int   pixels, total, count;
    logic op;
    pixels = w * h;
    total  = pixels + w + 1;
    if (h > 16) total = 3 * w + $urandom_range(2, 20);
    count = total;
    if (style == FRAME_CUT) count = $urandom_range(1, total - 1);
    if (style == FRAME_LONG) count = total + $urandom_range(1, 4);
    for (int i = 0; i < count; i++) begin
      op = (i >= pixels && i < total) ? box_blur_sb_pkg::OP_FLUSH
                                      : box_blur_sb_pkg::OP_PIXEL;
      if (style == FRAME_NOISY && $urandom_range(0, 7) == 0) op = ~op;
      send_item(op, pick_byte(fill), pick_byte(fill), pick_byte(fill));
    end
  endtask

  task automatic run_phase(input int phase_no);
    int           w_val, h_val, w, h, frames, pick;
    frame_style_t style;
    fill_t        fill;
    w_val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
    pick = $urandom_range(0, 9);
    if (pick == 0) h_val = $urandom_range(0, 2);
    else if (pick == 1) h_val = 8191;
    else if (pick == 2) h_val = box_blur_sb_pkg::MAX_ROWS;
    else h_val = $urandom_range(3, 6);
    pick = $urandom_range(0, 3);
    if (pick != 1) write_size_reg(bb_pkg::REG_FRAME_WIDTH, w_val);
    if (pick != 0) write_size_reg(bb_pkg::REG_FRAME_HEIGHT, h_val);
    w = sb.size_in_use(sb.width_reg, box_blur_sb_pkg::LINE_DEPTH);
    h = sb.size_in_use(sb.height_reg, box_blur_sb_pkg::MAX_ROWS);

    calm = ($urandom_range(0, 3) == 0);
    // now and then the receiver holds off while requests keep coming
    if (phase_no % 8 == 0) begin
      calm = 1'b1;
      hold_asked++;
    end

    frames = $urandom_range(1, 3);
    for (int f = 0; f < frames; f++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) style = FRAME_CLEAN;
      else if (pick == 7) style = FRAME_NOISY;
      else if (pick == 8) style = FRAME_CUT;
      else style = FRAME_LONG;
      pick = $urandom_range(0, 5);
      fill = (pick > 3) ? FILL_RANDOM : fill_t'(pick);
      send_frame(w, h, style, fill);
      if (style == FRAME_CUT) break;
    end
  endtask

  initial begin
    logic op;
    int   base, phase_no;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // smallest frame; bits above the width register are dropped
    write_size_reg(bb_pkg::REG_FRAME_WIDTH, 32'hFFFF_F803);
    write_size_reg(bb_pkg::REG_FRAME_HEIGHT, 32'd3);
    calm = 1'b1;
    // all white: full sums, darkened edges, flush payload ignored
    for (int i = 0; i < 13; i++)
      send_item(i < 9 ? box_blur_sb_pkg::OP_PIXEL : box_blur_sb_pkg::OP_FLUSH,
                8'hFF, 8'hFF, 8'hFF);
    // flush inside the frame and a data pixel among the flush slots
    for (int i = 0; i < 13; i++) begin
      op = (i == 4 || (i >= 9 && i != 10)) ? box_blur_sb_pkg::OP_FLUSH
                                            : box_blur_sb_pkg::OP_PIXEL;
      send_item(op, i[0] ? 8'hFF : 8'h00, (i % 3 == 0) ? 8'hFF : 8'h00, 8'(i * 37));
    end
    settle();

    // widest line and tallest frame, both saturated; only started
    write_size_reg(bb_pkg::REG_FRAME_WIDTH, 32'd2047);
    write_size_reg(bb_pkg::REG_FRAME_HEIGHT, 32'd8191);
    for (int i = 0; i < box_blur_sb_pkg::LINE_DEPTH + 16; i++)
      send_item(box_blur_sb_pkg::OP_PIXEL, pick_byte(FILL_RANDOM), pick_byte(FILL_RANDOM),
                pick_byte(FILL_RANDOM));
    settle();

    // zero sizes saturate up to three
    write_size_reg(bb_pkg::REG_FRAME_WIDTH, 32'd0);
    write_size_reg(bb_pkg::REG_FRAME_HEIGHT, 32'd0);
    send_frame(3, 3, FRAME_CLEAN, FILL_RANDOM);
    settle();

    // random phases
    base = items_sent;
    phase_no = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      run_phase(phase_no);
      phase_no++;
      settle();
    end
    calm = 1'b1;

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
